FILE: hw/rtl/ordered_list_search_delete_assert.svh
// Assertion macros for the ordered list checker
`ifndef ORDERED_LIST_SEARCH_DELETE_ASSERT_SVH
`define ORDERED_LIST_SEARCH_DELETE_ASSERT_SVH

// check consequent in the same cycle as the antecedent
`define OLSD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered list check failed");

// check consequent in the cycle after the antecedent
`define OLSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered list check failed");

`endif

FILE: hw/rtl/olsd_pkg.sv
// Shared types and constants for the ordered list block
package olsd_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned FIELD_W  = 7;
	localparam int unsigned OUT_D_W  = 16;
	localparam int unsigned OUT_U_W  = 3;

	typedef enum logic [1:0] {
		FUNC_PUSH_BACK,
		FUNC_PUSH_FRONT,
		FUNC_SEARCH,
		FUNC_DELETE
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_ABSENT,
		STATUS_FULL
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN
	} state_t;

endpackage

FILE: hw/rtl/olsd_ram.sv
// Entry store: one write port, one registered read port
module olsd_ram #(
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/ordered_list_search_delete.sv
// Top level of the bounded ordered list with search and delete
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  s_*      | in  | tuser: func[1:0]; tdata: value[31:0]
//  m_*      | out | tuser: status[1:0], found[2];
//           |     | tdata: position[6:0], entry_count[13:7], zero[15:14]
//
//  Inserts write the entry store directly; search is a read-compare walk
//  to a hit or past the last entry, and delete then moves each later entry
//  forward with a read-then-write shift through the entry store.
//  arst_n clears count, front index and handshake state; the store is not
//  cleared. One request is in flight at a time; a held result stalls the next.
module ordered_list_search_delete #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [olsd_pkg::VALUE_W-1:0]  s_tdata,  // value[31:0]
	input  logic [1:0]                    s_tuser,  // func[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [olsd_pkg::OUT_D_W-1:0]  m_tdata,  // position[6:0], entry_count[13:7], 0
	output logic [olsd_pkg::OUT_U_W-1:0]  m_tuser   // status[1:0], found[2]
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
	                                             input logic [SUM_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + offset;
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	olsd_pkg::state_t  state_q, state_d;
	olsd_pkg::func_t   func_q, func_d;
	olsd_pkg::status_t status_q, status_d;
	logic [olsd_pkg::VALUE_W-1:0] value_q, value_d;
	logic [IDX_W-1:0]  front_q, front_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic              found_q, found_d;
	logic              m_tvalid_q, m_tvalid_d;
	logic [olsd_pkg::OUT_D_W-1:0] out_data_q, out_data_d;
	logic [olsd_pkg::OUT_U_W-1:0] out_user_q, out_user_d;

	logic                          ram_we, ram_re;
	logic [IDX_W-1:0]              ram_waddr, ram_raddr;
	logic [olsd_pkg::VALUE_W-1:0]  ram_wdata, ram_rdata;

	logic             hit;
	logic             full;
	logic [CNT_W-1:0] idx_next;
	logic [SUM_W-1:0] idx_plus2;
	logic             next_in;
	logic             plus2_in;
	logic             out_free;

	assign hit      = (ram_rdata == value_q);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign idx_next = idx_q + 1'b1;
	assign idx_plus2 = SUM_W'(idx_q) + SUM_W'(2);
	assign next_in  = (idx_next < count_q);
	assign plus2_in = (idx_plus2 < SUM_W'(count_q));
	assign out_free = !m_tvalid_q || m_tready;

	olsd_ram #(
		.DEPTH  (CAPACITY),
		.DATA_W (olsd_pkg::VALUE_W)
	) u_olsd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olsd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					priority if (olsd_pkg::func_t'(s_tuser) == olsd_pkg::FUNC_PUSH_BACK
					             || olsd_pkg::func_t'(s_tuser) == olsd_pkg::FUNC_PUSH_FRONT
					             || count_q == '0) begin
						state_d = olsd_pkg::ST_FIN;
					end else begin
						state_d = olsd_pkg::ST_SCAN;
					end
				end
			end
			olsd_pkg::ST_SCAN: begin
				priority if (hit) begin
					state_d = (func_q == olsd_pkg::FUNC_DELETE && next_in)
					          ? olsd_pkg::ST_SHIFT : olsd_pkg::ST_FIN;
				end else if (!next_in) begin
					state_d = olsd_pkg::ST_FIN;
				end else begin
					state_d = olsd_pkg::ST_SCAN;
				end
			end
			olsd_pkg::ST_SHIFT: begin
				if (!plus2_in) begin
					state_d = olsd_pkg::ST_FIN;
				end
			end
			olsd_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = olsd_pkg::ST_IDLE;
				end
			end
			default: state_d = olsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == olsd_pkg::ST_IDLE);
		ram_we     = 1'b0;
		ram_waddr  = slot_of(front_q, SUM_W'(count_q));
		ram_wdata  = s_tdata;
		ram_re     = 1'b0;
		ram_raddr  = slot_of(front_q, SUM_W'(idx_next));
		func_d     = func_q;
		value_d    = value_q;
		status_d   = status_q;
		front_d    = front_q;
		count_d    = count_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		found_d    = found_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		out_data_d = out_data_q;
		out_user_d = out_user_q;
		unique case (state_q)
			olsd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					func_d   = olsd_pkg::func_t'(s_tuser);
					value_d  = s_tdata;
					status_d = olsd_pkg::STATUS_OK;
					found_d  = 1'b0;
					pos_d    = '0;
					idx_d    = '0;
					ram_raddr = front_q;
					unique case (olsd_pkg::func_t'(s_tuser))
						olsd_pkg::FUNC_PUSH_BACK: begin
							if (full) begin
								status_d = olsd_pkg::STATUS_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						olsd_pkg::FUNC_PUSH_FRONT: begin
							if (full) begin
								status_d = olsd_pkg::STATUS_FULL;
							end else begin
								front_d   = (front_q == '0) ? IDX_W'(CAPACITY - 1)
								                            : front_q - 1'b1;
								ram_we    = 1'b1;
								ram_waddr = front_d;
								count_d   = count_q + 1'b1;
							end
						end
						olsd_pkg::FUNC_SEARCH: begin
							if (count_q == '0) begin
								status_d = olsd_pkg::STATUS_ABSENT;
							end else begin
								ram_re = 1'b1;
							end
						end
						olsd_pkg::FUNC_DELETE: begin
							if (count_q == '0) begin
								status_d = olsd_pkg::STATUS_EMPTY;
							end else begin
								ram_re = 1'b1;
							end
						end
						default: status_d = olsd_pkg::STATUS_OK;
					endcase
				end
			end
			olsd_pkg::ST_SCAN: begin
				ram_re = next_in;
				priority if (hit) begin
					found_d = 1'b1;
					pos_d   = idx_next;
					if (func_q == olsd_pkg::FUNC_DELETE && !next_in) begin
						count_d = count_q - 1'b1;
					end
				end else if (!next_in) begin
					status_d = olsd_pkg::STATUS_ABSENT;
				end else begin
					idx_d = idx_next;
				end
			end
			olsd_pkg::ST_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_of(front_q, SUM_W'(idx_q));
				ram_wdata = ram_rdata;
				ram_re    = plus2_in;
				ram_raddr = slot_of(front_q, idx_plus2);
				idx_d     = idx_next;
				if (!plus2_in) begin
					count_d = count_q - 1'b1;
				end
			end
			olsd_pkg::ST_FIN: begin
				if (out_free) begin
					m_tvalid_d = 1'b1;
					out_data_d = {2'b00, olsd_pkg::FIELD_W'(count_q),
					              olsd_pkg::FIELD_W'(pos_q)};
					out_user_d = {found_q, status_q};
				end
			end
			default: m_tvalid_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= olsd_pkg::ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q     <= func_d;
		value_q    <= value_d;
		status_q   <= status_d;
		idx_q      <= idx_d;
		pos_q      <= pos_d;
		found_q    <= found_d;
		out_data_q <= out_data_d;
		out_user_q <= out_user_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

FILE: hw/rtl/olsd_checker.sv
// Port-level checker for the ordered list block, with its bind
`include "ordered_list_search_delete_assert.svh"

module olsd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [olsd_pkg::OUT_D_W-1:0] m_tdata,
	input logic [olsd_pkg::OUT_U_W-1:0] m_tuser
);

	`OLSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`OLSD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	`OLSD_ASSERT_NOW(a_found_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == olsd_pkg::STATUS_OK)
	`OLSD_ASSERT_NOW(a_miss_no_pos, m_tvalid && !m_tuser[2], m_tdata[6:0] == 7'd0)
	`OLSD_ASSERT_NOW(a_empty_count, m_tvalid && m_tuser[1:0] == olsd_pkg::STATUS_EMPTY, m_tdata[13:7] == 7'd0)

endmodule

bind ordered_list_search_delete olsd_checker u_olsd_checker (.*);
